### rtl/pba_pkg.sv
// Package for the page bitmap allocator.
// Holds sizes, command and status codes, the controller state type and helpers.
// No dependencies.
package pba_pkg;

  localparam int PAGES     = 4096;
  localparam int GROUPS    = PAGES / 8;
  localparam int GROUP_AW  = $clog2(GROUPS);
  localparam int PAGE_W    = 12;
  localparam int COUNT_W   = 13;

  localparam logic [7:0]         FULL_GROUP = 8'hFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 13'd8191;
  localparam logic [COUNT_W-1:0] PAGES_CNT  = 13'(PAGES);

  // Command codes.
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_RESERVE = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  // Controller states, one-hot.
  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_ARD   = 9'b000000100,
    S_ACHK  = 9'b000001000,
    S_RUN   = 9'b000010000,
    S_RLD   = 9'b000100000,
    S_MRD   = 9'b001000000,
    S_MWR   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  // Position of the lowest clear bit of a group word that is not full.
  function automatic logic [2:0] first_zero(input logic [7:0] w);
    logic [2:0] r;
    r = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (!w[k]) r = 3'(k);
    end
    return r;
  endfunction

endpackage

### rtl/page_bitmap_allocator_top.sv
// Top level of the page bitmap allocator: command controller around the bitmap RAM.
// Depends on pba_pkg and pba_ram.
//
//  channel | signals                                  | direction
//  in      | in_valid, in_stall, command, page_index, | request in
//          | run_length                               |
//  out     | out_valid, out_stall, status,            | result out
//          | granted_page, free_count                 |
//  cfg     | cfg_valid, cfg_ready, cfg_data           | pages_in_use write
//
// After reset the bitmap RAM is filled with ones, one 8-page group a cycle, over all
// 512 groups; no request is taken until the fill is done.
// An allocate passes the accept state, reads and checks each group visited (S_ARD, S_ACHK),
// checks the pages of a candidate run in turn in S_RUN with a reload (S_RLD) per group word
// it crosses into, reads and writes back each group word it marks (S_MRD, S_MWR), and
// hands off the result in S_DONE. Free and reserve read and write back each of the w group
// words the range touches (at most len/8 + 2), then hand off the result in S_DONE.
// A finished result waits in the output register while out_stall is high; a second
// one waits in the controller, and in_stall stays high until it moves on.
module page_bitmap_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [11:0] page_index,
  input  logic [12:0] run_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [11:0] granted_page,
  output logic [12:0] free_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);

  localparam int AW = pba_pkg::GROUP_AW;
  localparam int CW = pba_pkg::COUNT_W;

  pba_pkg::state_t state;

  logic [CW-1:0]   pages_in_use;
  logic [CW-1:0]   free_pages;
  logic [AW:0]     clr_cnt;
  logic [CW-1:0]   len;
  logic [AW:0]     grp;
  logic [11:0]     run_start;
  logic [CW-1:0]   run_n;
  logic [7:0]      buf_word;
  logic [AW-1:0]   buf_addr;
  logic [11:0]     mstart;
  logic [CW-1:0]   mlen;
  logic            mval;
  logic [CW-1:0]   mcnt;
  logic            alloc_ok;
  logic [1:0]      res_status;
  logic [11:0]     res_grant;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [7:0]      wdata;
  logic [AW-1:0]   raddr;
  logic [7:0]      rdata;

  logic [CW-1:0]   eff;
  logic [AW:0]     groups;
  logic [11:0]     cand;
  logic [CW-1:0]   pos;
  logic [CW-1:0]   mpos;
  logic [CW-1:0]   mrem;
  logic [2:0]      moff;
  logic [7:0]      mmask;
  logic [CW:0]     range_end;
  logic [CW:0]     free_sum;
  logic [CW-1:0]   free_sub;

  // Active page count and derived values.
  always_comb begin
    eff       = (pages_in_use < pba_pkg::PAGES_CNT) ? pages_in_use : pba_pkg::PAGES_CNT;
    groups    = (AW+1)'((eff + CW'(7)) >> 3);
    cand      = {grp[AW-1:0], pba_pkg::first_zero(rdata)};
    pos       = CW'(run_start) + run_n;
    mpos      = CW'(mstart) + mcnt;
    mrem      = mlen - mcnt;
    moff      = mpos[2:0];
    range_end = (CW+1)'(page_index) + (CW+1)'(run_length);
    free_sum  = (CW+1)'(free_pages) + (CW+1)'(run_length);
    free_sub  = (free_pages >= mlen) ? free_pages - mlen : '0;
    for (int k = 0; k < 8; k++) begin
      mmask[k] = (3'(k) >= moff) && (CW'(3'(k) - moff) < mrem);
    end
  end

  // RAM port selection.
  always_comb begin
    we    = 1'b0;
    waddr = mpos[AW+2:3];
    wdata = mval ? (rdata | mmask) : (rdata & ~mmask);
    raddr = grp[AW-1:0];
    unique case (state)
      pba_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt[AW-1:0];
        wdata = pba_pkg::FULL_GROUP;
      end
      pba_pkg::S_MWR:  we = 1'b1;
      pba_pkg::S_RUN:  raddr = pos[AW+2:3];
      pba_pkg::S_MRD:  raddr = mpos[AW+2:3];
      default: ;
    endcase
  end

  pba_ram #(.WIDTH(8), .DEPTH(pba_pkg::GROUPS)) u_bitmap (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_stall  = (state != pba_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use <= pba_pkg::PAGES_CNT;
    end else if (cfg_valid && cfg_ready) begin
      pages_in_use <= cfg_data;
    end
  end

  // Command controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pba_pkg::S_CLEAR;
      clr_cnt    <= '0;
      free_pages <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != pba_pkg::S_DONE) out_valid <= 1'b0;
      unique case (state)
        pba_pkg::S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(pba_pkg::GROUPS - 1)) state <= pba_pkg::S_IDLE;
        end
        pba_pkg::S_IDLE: begin
          if (in_valid) begin
            len        <= run_length;
            grp        <= '0;
            res_grant  <= '0;
            alloc_ok   <= 1'b0;
            mstart     <= page_index;
            mlen       <= run_length;
            mcnt       <= '0;
            if (command == pba_pkg::CMD_ALLOC) begin
              res_status <= pba_pkg::ST_NO_SPACE;
              state      <= (free_pages >= run_length) ? pba_pkg::S_ARD : pba_pkg::S_DONE;
            end else if ((command == pba_pkg::CMD_FREE ||
                          command == pba_pkg::CMD_RESERVE) &&
                         range_end <= (CW+1)'(eff)) begin
              res_status <= pba_pkg::ST_OK;
              mval       <= (command == pba_pkg::CMD_RESERVE);
              state      <= pba_pkg::S_MRD;
              if (command == pba_pkg::CMD_FREE) begin
                free_pages <= (free_sum > (CW+1)'(pba_pkg::COUNT_MAX)) ?
                              pba_pkg::COUNT_MAX : free_sum[CW-1:0];
              end else begin
                free_pages <= (free_pages >= run_length) ?
                              free_pages - run_length : '0;
              end
            end else begin
              res_status <= pba_pkg::ST_RANGE;
              state      <= pba_pkg::S_DONE;
            end
          end
        end
        pba_pkg::S_ARD: begin
          // Issue the read of the next group, or give up after the last one.
          if (grp >= groups) state <= pba_pkg::S_DONE;
          else               state <= pba_pkg::S_ACHK;
        end
        pba_pkg::S_ACHK: begin
          if (rdata == pba_pkg::FULL_GROUP || CW'(cand) >= eff) begin
            grp   <= grp + 1'b1;
            state <= pba_pkg::S_ARD;
          end else begin
            run_start <= cand;
            run_n     <= '0;
            buf_word  <= rdata;
            buf_addr  <= grp[AW-1:0];
            state     <= pba_pkg::S_RUN;
          end
        end
        pba_pkg::S_RUN: begin
          // Check one page of the candidate run per cycle, but for a reload (S_RLD) on entering a new group word.
          if (run_n == len) begin
            res_status <= pba_pkg::ST_OK;
            res_grant  <= run_start;
            alloc_ok   <= 1'b1;
            mstart     <= run_start;
            mval       <= 1'b1;
            state      <= pba_pkg::S_MRD;
          end else if (pos >= eff || (pos[AW+2:3] == buf_addr && buf_word[pos[2:0]])) begin
            grp   <= grp + 1'b1;
            state <= pba_pkg::S_ARD;
          end else if (pos[AW+2:3] != buf_addr) begin
            state <= pba_pkg::S_RLD;
          end else begin
            run_n <= run_n + 1'b1;
          end
        end
        pba_pkg::S_RLD: begin
          buf_word <= rdata;
          buf_addr <= pos[AW+2:3];
          state    <= pba_pkg::S_RUN;
        end
        pba_pkg::S_MRD: begin
          if (mcnt >= mlen) begin
            if (alloc_ok) free_pages <= free_sub;
            state <= pba_pkg::S_DONE;
          end else begin
            state <= pba_pkg::S_MWR;
          end
        end
        pba_pkg::S_MWR: begin
          mcnt  <= mcnt + CW'(4'd8 - {1'b0, moff});
          state <= pba_pkg::S_MRD;
        end
        pba_pkg::S_DONE: begin
          // Hand the result to the output register once it is free.
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            granted_page <= res_grant;
            free_count   <= free_pages;
            state        <= pba_pkg::S_IDLE;
          end
        end
        default: state <= pba_pkg::S_IDLE;
      endcase
    end
  end

endmodule

### rtl/pba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### test/tb_page_bitmap_allocator_top.sv
// Self-checking testbench for the page bitmap allocator: directed and random commands
// checked against a behavioral bitmap model. Depends on pba_pkg and page_bitmap_allocator_top.
`timescale 1ns / 1ps

module tb_page_bitmap_allocator_top;

  // One allocate may walk every group and every page of a candidate run.
  localparam int WATCHDOG_LIMIT = 10_000_000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  command;
  logic [11:0] page_index;
  logic [12:0] run_length;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [11:0] granted_page;
  logic [12:0] free_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [12:0] cfg_data;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] granted_page;
    logic [12:0] free_count;
  } alloc_result_t;

  // Behavioral copy of the bitmap, the free count and the page limit.
  logic          occupied [pba_pkg::PAGES];
  logic [12:0]   free_pages_m;
  logic [12:0]   pages_limit;
  alloc_result_t pending_results[$];

  int  errors;
  int  idle_cycles;
  bit  hold_long;

  page_bitmap_allocator_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .page_index(page_index), .run_length(run_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .granted_page(granted_page), .free_count(free_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  function automatic bit page_busy(int i);
    if (i >= pba_pkg::PAGES) return 1'b1;
    return occupied[i];
  endfunction

  // Compute the result of one command and update the bitmap copy.
  function automatic alloc_result_t apply_command(logic [1:0] cmd, logic [11:0] idx,
                                                  logic [12:0] len);
    alloc_result_t r;
    int eff;
    int p;
    int n;
    logic [7:0] occ;
    eff = (pages_limit < pba_pkg::PAGES) ? pages_limit : pba_pkg::PAGES;
    r.status = pba_pkg::ST_RANGE;
    r.granted_page = '0;
    if (cmd == pba_pkg::CMD_ALLOC) begin
      r.status = pba_pkg::ST_NO_SPACE;
      if (free_pages_m >= len) begin
        for (int g = 0; g < (eff + 7) / 8; g++) begin
          for (int k = 0; k < 8; k++) occ[k] = page_busy(g * 8 + k);
          if (occ == pba_pkg::FULL_GROUP) continue;
          p = g * 8;
          while (occ[0]) begin
            occ = occ >> 1;
            p++;
          end
          if (p >= eff) continue;
          n = 0;
          while (n < len && p + n < eff && !page_busy(p + n)) n++;
          if (n == len) begin
            for (int i = 0; i < len; i++) occupied[p + i] = 1'b1;
            free_pages_m = (free_pages_m >= len) ? free_pages_m - len : '0;
            r.status = pba_pkg::ST_OK;
            r.granted_page = p[11:0];
            break;
          end
        end
      end
    end else if (cmd == pba_pkg::CMD_FREE || cmd == pba_pkg::CMD_RESERVE) begin
      if (int'(idx) + int'(len) <= eff) begin
        r.status = pba_pkg::ST_OK;
        for (int i = 0; i < len; i++) occupied[idx + i] = (cmd == pba_pkg::CMD_RESERVE);
        if (cmd == pba_pkg::CMD_FREE) begin
          free_pages_m = (int'(free_pages_m) + len > pba_pkg::COUNT_MAX) ?
                         pba_pkg::COUNT_MAX : free_pages_m + len;
        end else begin
          free_pages_m = (free_pages_m >= len) ? free_pages_m - len : '0;
        end
      end
    end
    r.free_count = free_pages_m;
    return r;
  endfunction

  // Offer one request and wait for its transfer; a random gap may come first.
  // Valid stays high after the transfer until a gap or a drain drops it.
  task automatic send_command(logic [1:0] cmd, logic [11:0] idx, logic [12:0] len);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    page_index <= idx;
    run_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_command(cmd, idx, len));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_page_limit(logic [12:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pages_limit = value;
  endtask

  // Directed: extremes of every field, every command, and the special cases.
  task automatic test_directed();
    send_command(pba_pkg::CMD_ALLOC, 12'd0, 13'd1);          // nothing free yet
    send_command(pba_pkg::CMD_FREE, 12'd0, 13'd4096);        // whole map
    send_command(pba_pkg::CMD_ALLOC, 12'd0, 13'd0);          // zero length
    send_command(pba_pkg::CMD_ALLOC, 12'hFFF, 13'd4096);
    send_command(pba_pkg::CMD_FREE, 12'hFFF, 13'd2);         // out of range
    send_command(pba_pkg::CMD_RESERVE, 12'd0, 13'd4096);
    send_command(2'd3, 12'hFFF, 13'h1FFF);                   // unknown command
    send_command(pba_pkg::CMD_FREE, 12'd4095, 13'd1);
    send_command(pba_pkg::CMD_ALLOC, 12'd0, 13'd1);          // last page
    send_command(pba_pkg::CMD_FREE, 12'd3, 13'd10);
    send_command(pba_pkg::CMD_RESERVE, 12'd5, 13'd2);
    send_command(pba_pkg::CMD_ALLOC, 12'd0, 13'd4);          // candidate run blocked
    send_command(pba_pkg::CMD_ALLOC, 12'd0, 13'd5);
    send_command(pba_pkg::CMD_FREE, 12'd0, 13'd4096);        // count drift upward
    send_command(pba_pkg::CMD_FREE, 12'd0, 13'd4096);
    send_command(pba_pkg::CMD_FREE, 12'd0, 13'd4096);        // saturation
    send_command(pba_pkg::CMD_RESERVE, 12'd0, 13'h1FFF);     // out of range, 13-bit length
    send_command(pba_pkg::CMD_ALLOC, 12'd0, 13'd4096);
  endtask

  task automatic random_item(int eff);
    int pick;
    logic [12:0] len;
    pick = $urandom_range(0, 9);
    len = ($urandom_range(0, 15) == 0) ? 13'($urandom) : 13'($urandom_range(0, 24));
    if (pick < 4) begin
      send_command(pba_pkg::CMD_ALLOC, 12'($urandom), len);
    end else if (pick < 7) begin
      send_command(pba_pkg::CMD_FREE, 12'($urandom_range(0, (eff > 0) ? eff - 1 : 0)), len);
    end else if (pick < 9) begin
      send_command(pba_pkg::CMD_RESERVE, 12'($urandom_range(0, (eff > 0) ? eff - 1 : 0)),
                   len);
    end else begin
      send_command(2'($urandom), 12'($urandom), 13'($urandom));
    end
  endtask

  // Random: mostly small runs inside the active range, plus noise.
  task automatic test_random(int count);
    int eff;
    eff = (pages_limit < pba_pkg::PAGES) ? pages_limit : pba_pkg::PAGES;
    for (int i = 0; i < count; i++) random_item(eff);
  endtask

  // Long receiver hold while requests keep coming, then a full pause.
  task automatic test_backpressure();
    hold_long = 1'b1;
    test_random(20);
    drain_results();
  endtask

  task automatic test_page_limits();
    write_page_limit(13'd1);
    send_command(pba_pkg::CMD_FREE, 12'd0, 13'd1);
    test_random(30);
    write_page_limit(13'd0);
    send_command(pba_pkg::CMD_FREE, 12'd0, 13'd1);
    send_command(pba_pkg::CMD_ALLOC, 12'd0, 13'd0);
    write_page_limit(13'h1FFF);
    test_random(40);
    write_page_limit(13'd67);
    send_command(pba_pkg::CMD_FREE, 12'd0, 13'd67);
    test_random(200);
    write_page_limit(13'd4096);
  endtask

  // Receiver stall pattern, with a long hold on request.
  initial begin
    out_stall <= 1'b0;
    hold_long = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_long = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 7) < 3);
        repeat ($urandom_range(1, 12)) @(posedge clk);
        if ($urandom_range(0, 3) == 0) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, status);
          errors++;
        end
        if (granted_page !== want.granted_page) begin
          $error("granted_page expected %0d actual %0d", want.granted_page, granted_page);
          errors++;
        end
        if (free_count !== want.free_count) begin
          $error("free_count expected %0d actual %0d", want.free_count, free_count);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("tb_page_bitmap_allocator_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    command <= '0;
    page_index <= '0;
    run_length <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    for (int i = 0; i < pba_pkg::PAGES; i++) occupied[i] = 1'b1;
    free_pages_m = '0;
    pages_limit = 13'd4096;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(150);
    test_backpressure();
    test_page_limits();
    test_random(250);
    drain_results();
    if (errors == 0) begin
      $display("tb_page_bitmap_allocator_top OK");
    end else begin
      $display("tb_page_bitmap_allocator_top NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pba_pkg.sv
rtl/pba_ram.sv
rtl/page_bitmap_allocator_top.sv
test/tb_page_bitmap_allocator_top.sv
